>>> src/fplm_pkg.sv
// shared constants and types for the free polyomino library match block
// no dependencies
package fplm_pkg;
    localparam int GridSideDef = 8;
    localparam int LibDepthDef = 256;
    localparam int NumSymm     = 8;
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic       cell_filled;
        logic [6:0] shape_size;
        logic       last_cell;
    } in_item_t;

    typedef struct packed {
        logic [7:0] entry_index;
        logic       is_new;
        logic       library_full;
    } out_item_t;
endpackage

>>> src/fplm_if.sv
// valid/ready channel interfaces for the library match block
// depends on fplm_pkg
interface fplm_in_if;
    logic               valid;
    logic               ready;
    fplm_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fplm_out_if;
    logic                valid;
    logic                ready;
    fplm_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/fplm_ram.sv
// generic single port ram with registered read
// no dependencies
module fplm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> src/fplm_cell.sv
// one symmetry cell: holds one transformed candidate and compares it with
// the library word passing through; no dependencies
module fplm_cell #(
    parameter int CELLS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [CELLS-1:0] cand,
    input  logic [CELLS-1:0] lib_in,
    input  logic             lv_in,
    input  logic             hit_in,
    output logic [CELLS-1:0] lib_out,
    output logic             lv_out,
    output logic             hit_out
);
    logic [CELLS-1:0] cand_reg;

    // candidate capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cand_reg <= cand;
        end
        lib_out <= lib_in;
    end

    // hit flag and valid move one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_out  <= 1'b0;
            hit_out <= 1'b0;
        end
        else
        begin
            lv_out  <= lv_in & ~load;
            hit_out <= hit_in | (lv_in & (lib_in == cand_reg));
        end
    end
endmodule

>>> src/free_polyomino_library_match.sv
// top level of the free polyomino library match; depends on fplm_pkg,
// fplm_if, fplm_ram and fplm_cell
//
//  channel | dir | content
//  in_ch   | in  | opcode, cell_filled, shape_size, last_cell
//  out_ch  | out | entry_index, is_new, library_full
//
// a load or clear is taken while idle; a lookup shifts the eight transformed
// grids to their corners, then streams each library entry from the ram
// through the row of eight symmetry cells, then posts the result in the
// decide state and passes through the out state back to idle.
// reset empties the library at once (count cleared); no clearing pass.
// input waits while a lookup runs and while a result is not yet accepted.
module free_polyomino_library_match #(
    parameter int GRID_SIDE = fplm_pkg::GridSideDef,
    parameter int LIB_DEPTH = fplm_pkg::LibDepthDef
) (
    input logic     clk,
    input logic     rst_n,
    fplm_in_if.sink  in_ch,
    fplm_out_if.source out_ch
);
    import fplm_pkg::*;

    localparam int S  = GRID_SIDE;
    localparam int C  = S * S;
    localparam int PW = (C > 1) ? $clog2(C) : 1;
    localparam int AW = (LIB_DEPTH > 1) ? $clog2(LIB_DEPTH) : 1;
    localparam int CW = $clog2(LIB_DEPTH + 1);
    localparam int SW = $clog2(2 * S);
    localparam int TW = CW + 5;

    typedef enum logic [2:0] {ST_IDLE, ST_CORNER, ST_SCAN, ST_DECIDE, ST_OUT} state_t;

    state_t          state_reg;
    logic [C-1:0]    grid_reg;
    logic [PW-1:0]   pos_reg;
    logic [CW-1:0]   count_reg;
    logic [6:0]      size_reg;
    logic [C-1:0]    cand_reg [NumSymm];
    logic [SW-1:0]   shift_reg;
    logic [TW-1:0]   tick_reg;
    logic [AW-1:0]   scan_reg;
    logic            hit_seen_reg;
    logic [AW-1:0]   hit_idx_reg;
    out_item_t       res_reg;
    logic            res_valid_reg;

    logic            take;
    assign in_ch.ready  = (state_reg == ST_IDLE) && !res_valid_reg;
    assign take         = in_ch.valid && in_ch.ready;
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;

    // symmetry transforms of the grid
    function automatic logic [C-1:0] xform(logic [C-1:0] g, int t);
        logic [C-1:0] r;
        int sx, sy;
        r = '0;
        for (int y = 0; y < S; y++)
        begin
            for (int x = 0; x < S; x++)
            begin
                case (t)
                    0: begin sx = x;       sy = y;       end
                    1: begin sx = S-1-x;   sy = y;       end
                    2: begin sx = S-1-x;   sy = S-1-y;   end
                    3: begin sx = x;       sy = S-1-y;   end
                    4: begin sx = y;       sy = x;       end
                    5: begin sx = S-1-y;   sy = x;       end
                    6: begin sx = S-1-y;   sy = S-1-x;   end
                    default: begin sx = y; sy = S-1-x;   end
                endcase
                r[x + S*y] = g[sx + S*sy];
            end
        end
        return r;
    endfunction

    // one corner step: shift left a column if column 0 empty, else up a row if row 0 empty
    function automatic logic [C-1:0] corner_step(logic [C-1:0] g);
        logic colz, rowz;
        logic [C-1:0] r;
        colz = 1'b1;
        rowz = 1'b1;
        for (int y = 0; y < S; y++) colz &= ~g[S*y];
        for (int x = 0; x < S; x++) rowz &= ~g[x];
        r = g;
        if (g == '0)
        begin
            r = g;
        end
        else if (colz)
        begin
            for (int y = 0; y < S; y++)
                for (int x = 0; x < S; x++)
                    r[x + S*y] = (x < S-1) ? g[x + 1 + S*y] : 1'b0;
        end
        else if (rowz)
        begin
            r = g >> S;
        end
        return r;
    endfunction

    // library ram: occupancy plus size
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [C+6:0]    ram_rdata;
    fplm_ram #(.WIDTH(C + 7), .DEPTH(LIB_DEPTH)) u_lib (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({size_reg, cand_reg[0]}),
        .rdata (ram_rdata)
    );

    // entry valid when read inside count and size equals
    logic rd_valid_reg;
    logic [AW-1:0] rd_idx_reg;
    logic lv0;
    assign lv0 = rd_valid_reg && (ram_rdata[C+6:C] == size_reg);

    // cells take their candidates in the first scan cycle
    logic cell_load;
    assign cell_load = (state_reg == ST_SCAN) && (tick_reg == '0);

    // chain of symmetry cells
    logic [C-1:0] lib_c [NumSymm+1];
    logic         lv_c  [NumSymm+1];
    logic         hit_c [NumSymm+1];
    logic [AW-1:0] idx_pipe_reg [NumSymm];
    assign lib_c[0] = ram_rdata[C-1:0];
    assign lv_c[0]  = lv0;
    assign hit_c[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < NumSymm; gi++)
        begin : g_cell
            fplm_cell #(.CELLS(C)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (cell_load),
                .cand    (cand_reg[gi]),
                .lib_in  (lib_c[gi]),
                .lv_in   (lv_c[gi]),
                .hit_in  (1'b0),
                .lib_out (lib_c[gi+1]),
                .lv_out  (lv_c[gi+1]),
                .hit_out (hit_c[gi+1])
            );
        end
    endgenerate

    // per-symmetry hit: a cell's hit_out reflects the entry it saw last cycle
    logic [NumSymm-1:0] hit_vec;
    logic [AW-1:0]      hidx [NumSymm];
    always_comb
    begin
        for (int k = 0; k < NumSymm; k++)
        begin
            hit_vec[k] = hit_c[k+1];
            hidx[k]    = idx_pipe_reg[k];
        end
    end

    // best hit so far: symmetry first, then lowest index
    logic [3:0]    best_sym_reg;
    logic [3:0]    cur_sym;
    logic [AW-1:0] cur_idx;
    logic          cur_hit;
    always_comb
    begin
        cur_hit = 1'b0;
        cur_sym = 4'd8;
        cur_idx = '0;
        for (int k = NumSymm-1; k >= 0; k--)
        begin
            if (hit_vec[k])
            begin
                cur_hit = 1'b1;
                cur_sym = 4'(k);
                cur_idx = hidx[k];
            end
        end
    end

    assign ram_we   = (state_reg == ST_DECIDE) && !hit_seen_reg
                      && (count_reg < CW'(LIB_DEPTH));
    assign ram_addr = (state_reg == ST_DECIDE) ? count_reg[AW-1:0] : scan_reg;

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= scan_reg;
        idx_pipe_reg[0] <= rd_idx_reg;
        for (int k = 1; k < NumSymm; k++)
            idx_pipe_reg[k] <= idx_pipe_reg[k-1];
    end

    // grid with the incoming cell merged in
    logic [C-1:0] grid_next;
    assign grid_next = (grid_reg & ~(C'(1) << pos_reg))
                       | (C'(in_ch.data.cell_filled) << pos_reg);

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grid_reg      <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            hit_seen_reg  <= 1'b0;
            tick_reg      <= '0;
            shift_reg     <= '0;
            scan_reg      <= '0;
            best_sym_reg  <= 4'd8;
            hit_idx_reg   <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                res_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        if (in_ch.data.opcode == OP_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                        else
                        begin
                            grid_reg[pos_reg] <= in_ch.data.cell_filled;
                            pos_reg <= (pos_reg == PW'(C-1)) ? '0 : pos_reg + 1'b1;
                            size_reg <= in_ch.data.shape_size;
                            if (in_ch.data.last_cell)
                            begin
                                for (int k = 0; k < NumSymm; k++)
                                    cand_reg[k] <= xform(grid_next, k);
                                shift_reg <= '0;
                                state_reg <= ST_CORNER;
                            end
                        end
                    end
                end
                ST_CORNER:
                begin
                    for (int k = 0; k < NumSymm; k++)
                        cand_reg[k] <= corner_step(cand_reg[k]);
                    shift_reg <= shift_reg + 1'b1;
                    if (shift_reg == SW'(2 * S - 2))
                    begin
                        state_reg    <= ST_SCAN;
                        scan_reg     <= '0;
                        tick_reg     <= '0;
                        hit_seen_reg <= 1'b0;
                        best_sym_reg <= 4'd8;
                    end
                end
                ST_SCAN:
                begin
                    if (TW'(scan_reg) < TW'(count_reg) && tick_reg < TW'(count_reg))
                    begin
                        rd_valid_reg <= 1'b1;
                        scan_reg <= scan_reg + 1'b1;
                    end
                    tick_reg <= tick_reg + 1'b1;
                    if (cur_hit && (cur_sym < best_sym_reg ||
                        (cur_sym == best_sym_reg && cur_idx < hit_idx_reg)))
                    begin
                        hit_seen_reg <= 1'b1;
                        best_sym_reg <= cur_sym;
                        hit_idx_reg  <= cur_idx;
                    end
                    if (tick_reg == TW'(count_reg) + TW'(NumSymm + 2))
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    res_valid_reg <= 1'b1;
                    grid_reg <= '0;
                    pos_reg  <= '0;
                    if (hit_seen_reg)
                    begin
                        res_reg <= '{entry_index: 8'(hit_idx_reg), is_new: 1'b0,
                                     library_full: 1'b0};
                    end
                    else if (count_reg < CW'(LIB_DEPTH))
                    begin
                        res_reg <= '{entry_index: 8'(count_reg), is_new: 1'b1,
                                     library_full: 1'b0};
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        res_reg <= '{entry_index: 8'd0, is_new: 1'b0,
                                     library_full: 1'b1};
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

>>> src/fplm_check.sv
// port-level checks for the library match block
// depends on fplm_if, bound to free_polyomino_library_match
module fplm_check (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic is_new,
    input logic library_full
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && library_full)) else $error("new and full");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken with result waiting");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_valid && in_ready)) else $error("transfer while result waits");
endmodule

bind free_polyomino_library_match fplm_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .is_new       (out_ch.data.is_new),
    .library_full (out_ch.data.library_full)
);
